/* hdl/sml_pkg.sv */
package sml_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_LOOKUP_LINE   = 2'd0;
    localparam logic [1:0] REG_TARGET_COLUMN = 2'd1;
    localparam logic [1:0] REG_NUM_SOURCES   = 2'd2;

    // Separator characters
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    // VLQ limits: shift value at which an eighth digit arrives
    localparam logic [5:0] SHIFT_LIMIT = 6'd35;
    localparam logic [5:0] SHIFT_STEP  = 6'd5;

    // Field counts of a segment
    localparam logic [2:0] FIELDS_SOURCED = 3'd4;
    localparam logic [2:0] FIELDS_MAX     = 3'd5;

    typedef struct packed {
        logic        found;
        logic        fault;
        logic [7:0]  source_index;
        logic [31:0] original_line;
        logic [31:0] original_column;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [5:0]  value;
    } digit_t;

    // Base64 character to 6-bit digit
    function automatic digit_t b64_decode(input logic [7:0] c);
        digit_t d;
        d.valid = 1'b1;
        d.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            d.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            d.value = 6'(c - 8'h61) + 6'd26;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = 6'(c - 8'h30) + 6'd52;
        end
        else if (c == 8'h2B)
        begin
            d.value = 6'd62;
        end
        else if (c == 8'h2F)
        begin
            d.value = 6'd63;
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

/* hdl/sml_scan_core.sv */
module sml_scan_core #(
    parameter int MAX_SOURCES = 256,
    parameter int LINE_BITS   = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        symbol,
    input  logic              end_of_text,
    input  logic [23:0]       lookup_line,
    input  logic [23:0]       target_column,
    input  logic [8:0]        num_sources,
    output logic              emit,
    output sml_pkg::result_t  result
);
    import sml_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [31:0] MAX_SRC = 32'(MAX_SOURCES);

    // Scan state
    logic [31:0]          acc_reg, acc_next;
    logic [5:0]           shift_reg, shift_next;
    logic [2:0]           fn_reg, fn_next;
    logic [31:0]          delta_reg [4];
    logic [31:0]          delta_next [4];
    logic [31:0]          gcol_reg, gcol_next;
    logic [31:0]          src_reg, src_next;
    logic [31:0]          oline_reg, oline_next;
    logic [31:0]          ocol_reg, ocol_next;
    logic [LINE_BITS-1:0] lc_reg, lc_next;
    logic [7:0]           hit_src_reg, hit_src_next;
    logic [31:0]          hit_line_reg, hit_line_next;
    logic [31:0]          hit_col_reg, hit_col_next;
    logic                 hit_valid_reg, hit_valid_next;
    logic                 done_reg, done_next;

    // Working signals
    digit_t       dig;
    logic         is_comma, is_semi, is_sep;
    logic [36:0]  digit_wide;
    logic [31:0]  acc_or, mag, val;
    logic         fault_now, emitted, sourced, on_target, col_ok;
    logic [31:0]  gsum, ssum, tl_m1, tcol, lim;

    assign dig        = b64_decode(symbol);
    assign is_comma   = (symbol == CHAR_COMMA);
    assign is_semi    = (symbol == CHAR_SEMI);
    assign is_sep     = is_comma || is_semi;
    assign digit_wide = {32'd0, dig.value[4:0]} << shift_reg;
    assign acc_or     = acc_reg | digit_wide[31:0];
    assign mag        = {1'b0, acc_or[31:1]};
    assign val        = acc_or[0] ? (32'd0 - mag) : mag;

    // Target compares
    assign tl_m1     = 32'(lookup_line) - 32'd1;
    assign on_target = (lookup_line != 24'd0) && (lc_reg != LINE_MAX) &&
                       (32'(lc_reg) == tl_m1);
    assign tcol      = (target_column == 24'd0) ? 32'd0 : 32'(target_column) - 32'd1;
    assign lim       = (32'(num_sources) < MAX_SRC) ? 32'(num_sources) : MAX_SRC;

    // Per-character update
    always_comb
    begin
        acc_next       = acc_reg;
        shift_next     = shift_reg;
        fn_next        = fn_reg;
        delta_next     = delta_reg;
        gcol_next      = gcol_reg;
        src_next       = src_reg;
        oline_next     = oline_reg;
        ocol_next      = ocol_reg;
        lc_next        = lc_reg;
        hit_src_next   = hit_src_reg;
        hit_line_next  = hit_line_reg;
        hit_col_next   = hit_col_reg;
        hit_valid_next = hit_valid_reg;
        fault_now      = 1'b0;
        emitted        = 1'b0;
        sourced        = 1'b0;
        col_ok         = 1'b0;
        gsum           = gcol_reg;
        ssum           = src_reg;
        result         = '0;

        // digit or bad character
        if (!done_reg)
        begin
            if (dig.valid)
            begin
                if (shift_reg >= SHIFT_LIMIT)
                begin
                    fault_now = 1'b1;
                end
                else if (dig.value[5])
                begin
                    acc_next   = acc_or;
                    shift_next = shift_reg + SHIFT_STEP;
                end
                else
                begin
                    acc_next   = 32'd0;
                    shift_next = 6'd0;
                    if (fn_reg >= FIELDS_MAX)
                    begin
                        fault_now = 1'b1;
                    end
                    else
                    begin
                        if (fn_reg < FIELDS_SOURCED)
                        begin
                            delta_next[fn_reg[1:0]] = val;
                        end
                        fn_next = fn_reg + 3'd1;
                    end
                end
            end
            else if (!is_sep)
            begin
                fault_now = 1'b1;
            end
        end

        // segment close
        if (!done_reg && !fault_now && (is_sep || end_of_text))
        begin
            if (shift_next != 6'd0)
            begin
                fault_now = 1'b1;
            end
            else if (fn_next == 3'd0)
            begin
                fault_now = 1'b0;
            end
            else if (fn_next == 3'd2 || fn_next == 3'd3)
            begin
                fault_now = 1'b1;
            end
            else
            begin
                sourced   = (fn_next >= FIELDS_SOURCED);
                gsum      = gcol_reg + delta_next[0];
                ssum      = src_reg + delta_next[1];
                gcol_next = gsum;
                if (sourced)
                begin
                    src_next   = ssum;
                    oline_next = oline_reg + delta_next[2];
                    ocol_next  = ocol_reg + delta_next[3];
                end
                fn_next    = 3'd0;
                delta_next = '{default: 32'd0};
                col_ok     = ($signed(gsum) <= $signed(tcol));
                if (on_target && col_ok)
                begin
                    if (sourced)
                    begin
                        if (ssum[31] || ssum >= lim)
                        begin
                            fault_now = 1'b1;
                        end
                        else
                        begin
                            hit_src_next   = ssum[7:0];
                            hit_line_next  = oline_next + 32'd1;
                            hit_col_next   = ocol_next + 32'd1;
                            hit_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        hit_valid_next = 1'b0;
                    end
                end
            end
        end

        // result selection
        if (fault_now)
        begin
            emitted      = 1'b1;
            result.fault = 1'b1;
        end
        else if (!done_reg)
        begin
            if (is_semi && on_target)
            begin
                emitted = 1'b1;
            end
            else if (is_semi)
            begin
                if (lc_reg != LINE_MAX)
                begin
                    lc_next = lc_reg + 1'b1;
                end
                gcol_next = 32'd0;
            end
            if (end_of_text)
            begin
                emitted = 1'b1;
            end
            if (emitted && hit_valid_next)
            begin
                result.found           = 1'b1;
                result.source_index    = hit_src_next;
                result.original_line   = hit_line_next;
                result.original_column = hit_col_next;
            end
        end
        emit      = emitted;
        done_next = done_reg | emitted;

        // end of text: back to a fresh scan
        if (end_of_text)
        begin
            acc_next       = 32'd0;
            shift_next     = 6'd0;
            fn_next        = 3'd0;
            delta_next     = '{default: 32'd0};
            gcol_next      = 32'd0;
            src_next       = 32'd0;
            oline_next     = 32'd0;
            ocol_next      = 32'd0;
            lc_next        = '0;
            hit_src_next   = 8'd0;
            hit_line_next  = 32'd0;
            hit_col_next   = 32'd0;
            hit_valid_next = 1'b0;
            done_next      = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 32'd0;
            shift_reg     <= 6'd0;
            fn_reg        <= 3'd0;
            delta_reg     <= '{default: 32'd0};
            gcol_reg      <= 32'd0;
            src_reg       <= 32'd0;
            oline_reg     <= 32'd0;
            ocol_reg      <= 32'd0;
            lc_reg        <= '0;
            hit_src_reg   <= 8'd0;
            hit_line_reg  <= 32'd0;
            hit_col_reg   <= 32'd0;
            hit_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else if (fire)
        begin
            acc_reg       <= acc_next;
            shift_reg     <= shift_next;
            fn_reg        <= fn_next;
            delta_reg     <= delta_next;
            gcol_reg      <= gcol_next;
            src_reg       <= src_next;
            oline_reg     <= oline_next;
            ocol_reg      <= ocol_next;
            lc_reg        <= lc_next;
            hit_src_reg   <= hit_src_next;
            hit_line_reg  <= hit_line_next;
            hit_col_reg   <= hit_col_next;
            hit_valid_reg <= hit_valid_next;
            done_reg      <= done_next;
        end
    end

endmodule

/* hdl/sml_result_reg.sv */
module sml_result_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sml_pkg::result_t  result_in,
    input  logic              out_stall,
    output logic              out_valid,
    output sml_pkg::result_t  result_out
);
    import sml_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Valid flag: set on load, cleared once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

/* hdl/source_map_position_lookup.sv */
// Source-map mappings lookup: one mappings character per cycle.
// A character's result goes from the input register through the scan core into the
// result register.
// Throughput: one character per cycle; the input stalls only while a result waits
// in the result register under out_stall.
// Reset (rst_n, async, active low) clears the scan and sets the three config registers to 1.
module source_map_position_lookup #(
    parameter int MAX_SOURCES = 256,
    parameter int LINE_BITS   = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // character channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  symbol,
    input  logic        end_of_text,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic        fault,
    output logic [7:0]  source_index,
    output logic signed [31:0] original_line,
    output logic signed [31:0] original_column,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import sml_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  symbol_reg;
    logic        eot_reg;
    logic [23:0] lookup_line_reg;
    logic [23:0] target_column_reg;
    logic [8:0]  num_sources_reg;
    logic        proc_fire;
    logic        emit;
    result_t     core_result;
    result_t     out_result;

    // Input register advances unless a result is held under stall
    assign in_stall  = in_valid_reg && out_valid && out_stall;
    assign proc_fire = in_valid_reg && !(out_valid && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            symbol_reg <= symbol;
            eot_reg    <= end_of_text;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_line_reg   <= 24'd1;
            target_column_reg <= 24'd1;
            num_sources_reg   <= 9'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LOOKUP_LINE:   lookup_line_reg   <= cfg_data;
                REG_TARGET_COLUMN: target_column_reg <= cfg_data;
                REG_NUM_SOURCES:   num_sources_reg   <= cfg_data[8:0];
                default:           lookup_line_reg   <= lookup_line_reg;
            endcase
        end
    end

    // Scan and match
    sml_scan_core #(
        .MAX_SOURCES (MAX_SOURCES),
        .LINE_BITS   (LINE_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (proc_fire),
        .symbol        (symbol_reg),
        .end_of_text   (eot_reg),
        .lookup_line   (lookup_line_reg),
        .target_column (target_column_reg),
        .num_sources   (num_sources_reg),
        .emit          (emit),
        .result        (core_result)
    );

    // Result register
    sml_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (proc_fire && emit),
        .result_in  (core_result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .result_out (out_result)
    );

    assign found           = out_result.found;
    assign fault           = out_result.fault;
    assign source_index    = out_result.source_index;
    assign original_line   = $signed(out_result.original_line);
    assign original_column = $signed(out_result.original_column);

endmodule

/* bench/source_map_position_lookup_tb.sv */
module source_map_position_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sml_pkg::*;

    typedef logic [7:0] text_t[$];

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 95;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 6;

    // Expected lookups: tracks the scan of the mappings text and queues results
    class mapping_lookup_scoreboard;
        logic [23:0] tgt_line;
        logic [23:0] tgt_col;
        logic [8:0]  src_count;

        logic [31:0] vlq_acc;
        int unsigned vlq_shift;
        int unsigned nfields;
        logic [31:0] seg_delta [4];
        logic [31:0] gen_col;
        logic [31:0] run_src;
        logic [31:0] run_line;
        logic [31:0] run_col;
        logic [23:0] line_no;
        logic [31:0] hit_src;
        logic [31:0] hit_line;
        logic [31:0] hit_col;
        bit          hit_ok;
        bit          done;

        result_t expected_lookups[$];
        int errors;
        int results;
        int hits;
        int faults;

        function new();
            clear_scan();
            tgt_line  = 24'd1;
            tgt_col   = 24'd1;
            src_count = 9'd1;
            errors    = 0;
            results   = 0;
            hits      = 0;
            faults    = 0;
        endfunction

        function void clear_scan();
            vlq_acc   = '0;
            vlq_shift = 0;
            nfields   = 0;
            foreach (seg_delta[i])
            begin
                seg_delta[i] = '0;
            end
            gen_col  = '0;
            run_src  = '0;
            run_line = '0;
            run_col  = '0;
            line_no  = '0;
            hit_src  = '0;
            hit_line = '0;
            hit_col  = '0;
            hit_ok   = 1'b0;
            done     = 1'b0;
        endfunction

        function void set_register(logic [1:0] idx, logic [23:0] data);
            case (idx)
                REG_LOOKUP_LINE:   tgt_line  = data;
                REG_TARGET_COLUMN: tgt_col   = data;
                REG_NUM_SOURCES:   src_count = data[8:0];
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("%0t ERROR %s", $time, msg);
            errors++;
        endtask

        function void emit(bit with_hit, bit bad);
            result_t r;
            r.found           = with_hit;
            r.fault           = bad;
            r.source_index    = with_hit ? hit_src[7:0] : 8'd0;
            r.original_line   = with_hit ? hit_line : 32'd0;
            r.original_column = with_hit ? hit_col : 32'd0;
            expected_lookups.push_back(r);
            done = 1'b1;
        endfunction

        function bit on_target();
            return tgt_line != 24'd0 && line_no != 24'hFFFFFF &&
                   line_no == tgt_line - 24'd1;
        endfunction

        function int digit_of(logic [7:0] c);
            if (c >= "A" && c <= "Z") return int'(c) - int'("A");
            if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
            if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
            if (c == "+") return 62;
            if (c == "/") return 63;
            return -1;
        endfunction

        // Apply the deltas of a finished segment and update the hit
        function void close_segment();
            bit     sourced;
            longint col_lim;
            longint src_lim;
            longint src_val;
            if (vlq_shift != 0)
            begin
                emit(1'b0, 1'b1);
                return;
            end
            if (nfields == 0) return;
            if (nfields == 2 || nfields == 3)
            begin
                emit(1'b0, 1'b1);
                return;
            end
            sourced = nfields >= 4;
            gen_col += seg_delta[0];
            if (sourced)
            begin
                run_src  += seg_delta[1];
                run_line += seg_delta[2];
                run_col  += seg_delta[3];
            end
            nfields = 0;
            foreach (seg_delta[i])
            begin
                seg_delta[i] = '0;
            end
            if (!on_target()) return;
            col_lim = (tgt_col == 24'd0) ? 0 : longint'(tgt_col) - 1;
            if (longint'($signed(gen_col)) > col_lim) return;
            if (!sourced)
            begin
                hit_ok = 1'b0;
                return;
            end
            src_lim = (src_count < 9'd256) ? longint'(src_count) : 256;
            src_val = longint'($signed(run_src));
            if (src_val < 0 || src_val >= src_lim)
            begin
                emit(1'b0, 1'b1);
                return;
            end
            hit_src  = run_src;
            hit_line = run_line + 32'd1;
            hit_col  = run_col + 32'd1;
            hit_ok   = 1'b1;
        endfunction

        // One base64 digit of a VLQ value
        function void take_digit(logic [5:0] d);
            logic [31:0] mag;
            logic [31:0] val;
            if (vlq_shift >= 35)
            begin
                emit(1'b0, 1'b1);
                return;
            end
            vlq_acc |= 32'(64'(d[4:0]) << vlq_shift);
            if (d[5])
            begin
                vlq_shift += 5;
                return;
            end
            mag = vlq_acc >> 1;
            val = vlq_acc[0] ? 32'd0 - mag : mag;
            vlq_acc   = '0;
            vlq_shift = 0;
            if (nfields >= 5)
            begin
                emit(1'b0, 1'b1);
                return;
            end
            if (nfields < 4) seg_delta[nfields] = val;
            nfields++;
        endfunction

        // Note one accepted character transfer
        function void take_symbol(logic [7:0] c, logic eot);
            int d;
            if (!done)
            begin
                d = digit_of(c);
                if (d >= 0)
                begin
                    take_digit(6'(d));
                end
                else if (c == CHAR_COMMA || c == CHAR_SEMI)
                begin
                    close_segment();
                    if (!done && c == CHAR_SEMI)
                    begin
                        if (on_target())
                        begin
                            emit(hit_ok, 1'b0);
                        end
                        else
                        begin
                            if (line_no != 24'hFFFFFF) line_no++;
                            gen_col = '0;
                        end
                    end
                end
                else
                begin
                    emit(1'b0, 1'b1);
                end
            end
            if (eot)
            begin
                if (!done)
                begin
                    close_segment();
                    if (!done) emit(hit_ok, 1'b0);
                end
                clear_scan();
            end
        endfunction

        // Compare one result transfer with the oldest expected lookup
        task check_lookup(result_t got);
            result_t want;
            if (expected_lookups.size() == 0)
            begin
                report("result with no lookup pending");
                return;
            end
            want = expected_lookups.pop_front();
            results++;
            if (want.found) hits++;
            if (want.fault) faults++;
            if (got.found !== want.found)
                report($sformatf("found %b, want %b", got.found, want.found));
            if (got.fault !== want.fault)
                report($sformatf("fault %b, want %b", got.fault, want.fault));
            if (got.source_index !== want.source_index)
                report($sformatf("source_index %0d, want %0d",
                                 got.source_index, want.source_index));
            if (got.original_line !== want.original_line)
                report($sformatf("original_line %h, want %h",
                                 got.original_line, want.original_line));
            if (got.original_column !== want.original_column)
                report($sformatf("original_column %h, want %h",
                                 got.original_column, want.original_column));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  symbol = 8'd0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic        fault;
    logic [7:0]  source_index;
    logic signed [31:0] original_line;
    logic signed [31:0] original_column;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [23:0] cfg_data = 24'd0;

    mapping_lookup_scoreboard sb = new();

    int gap_pct = 0;
    int stall_pct = 0;
    int pressure_reqs = 0;
    int pressure_seen = 0;
    int hold_left = 0;
    int sent_items = 0;
    int sent_texts = 0;
    int settings_used = 0;

    source_map_position_lookup u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .symbol          (symbol),
        .end_of_text     (end_of_text),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .fault           (fault),
        .source_index    (source_index),
        .original_line   (original_line),
        .original_column (original_column),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #2 clk = ~clk;

    // Result monitor
    always @(posedge clk)
    begin
        result_t got;
        got.found           = found;
        got.fault           = fault;
        got.source_index    = source_index;
        got.original_line   = original_line;
        got.original_column = original_column;
        if (rst_n && out_valid && !out_stall) sb.check_lookup(got);
    end

    // Receiver stall: random, or a long hold-off on request
    always @(posedge clk)
    begin
        if (pressure_seen != pressure_reqs)
        begin
            hold_left     = HOLD_CYCLES;
            pressure_seen = pressure_reqs;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t timeout with %0d lookups pending", $time, sb.expected_lookups.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] b64_char(logic [5:0] d);
        if (d < 26) return 8'("A" + d);
        if (d < 52) return 8'("a" + d - 26);
        if (d < 62) return 8'("0" + d - 52);
        return (d == 6'd62) ? 8'("+") : 8'("/");
    endfunction

    // VLQ digits of a value, padded with zero digits up to min_digits
    function automatic text_t vlq_chars(longint value, int min_digits);
        text_t s;
        longint unsigned code;
        logic [5:0] d;
        int n;
        n = 0;
        code = (value < 0) ? (unsigned'(-value) << 1) | 64'd1 : unsigned'(value) << 1;
        do
        begin
            d = 6'(code & 31);
            code = code >> 5;
            n++;
            if (code != 0 || n < min_digits) d[5] = 1'b1;
            s.push_back(b64_char(d));
        end
        while (d[5]);
        return s;
    endfunction

    function automatic longint pick_delta(int field);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return longint'($signed($urandom));
        case (field)
            0: return longint'($urandom_range(0, 6)) - 1;
            1: return (r < 70) ? 0 : longint'($urandom_range(0, 2)) - 1;
            default: return longint'($urandom_range(0, 20)) - 10;
        endcase
    endfunction

    // Random mappings text: mostly well-formed lines, some noise and damage
    function automatic text_t build_text();
        text_t txt;
        text_t noise_pool;
        int nlines;
        int nseg;
        int nf;
        int r;
        noise_pool = '{"A", "g", "C", ",", ";", "/", "+", "9", "z"};
        if ($urandom_range(0, 99) < 10)
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 2) == 0)
                    txt.push_back(8'($urandom_range(0, 255)));
                else
                    txt.push_back(noise_pool[$urandom_range(0, noise_pool.size() - 1)]);
            end
            return txt;
        end
        nlines = $urandom_range(1, 4);
        for (int l = 0; l < nlines; l++)
        begin
            nseg = $urandom_range(0, 4);
            for (int s = 0; s < nseg; s++)
            begin
                if (s > 0) txt.push_back(CHAR_COMMA);
                r = $urandom_range(0, 99);
                nf = (r < 40) ? 4 : (r < 65) ? 5 : (r < 85) ? 1 : (r < 90) ? 0 :
                     (r < 94) ? 2 : (r < 97) ? 3 : 6;
                for (int f = 0; f < nf; f++)
                begin
                    txt = {txt, vlq_chars(pick_delta(f),
                           ($urandom_range(0, 99) < 3) ? int'($urandom_range(2, 8)) : 1)};
                end
                // dangling continuation digit
                if ($urandom_range(0, 99) < 2) txt.push_back("g");
            end
            if (l < nlines - 1 || $urandom_range(0, 3) == 0) txt.push_back(CHAR_SEMI);
        end
        if ($urandom_range(0, 99) < 4)
            txt.insert($urandom_range(0, txt.size()), 8'($urandom_range(0, 255)));
        if (txt.size() == 0) txt.push_back(CHAR_COMMA);
        return txt;
    endfunction

    // One character transfer, with random gaps before it
    task automatic send_symbol(logic [7:0] c, logic eot);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        symbol      <= c;
        end_of_text <= eot;
        do @(posedge clk); while (in_stall);
        sb.take_symbol(c, eot);
        sent_items++;
    endtask

    task automatic send_text(text_t txt);
        foreach (txt[i])
        begin
            send_symbol(txt[i], i == txt.size() - 1);
        end
        sent_texts++;
    endtask

    task automatic send_str(string s);
        text_t txt;
        for (int i = 0; i < s.len(); i++)
        begin
            txt.push_back(s[i]);
        end
        send_text(txt);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    // Stop sending and let every pending lookup drain out
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_lookups.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned ph_line [7] = '{1, 2, 3, 1, 0, 24'hFFFFFF, 2};
        int unsigned ph_col  [7] = '{0, 5, 24'hFFFFFF, 8, 3, 2, 12};
        int unsigned ph_cnt  [7] = '{1, 4, 256, 0, 3, 511, 300};
        int unsigned ln;
        int unsigned col;
        int unsigned cnt;
        int phase_end;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts at reset settings
        send_str("AAAA;");       // target line closed by ';'
        send_str("AA,");         // two-value segment
        send_text('{8'h00});     // NUL
        send_text('{8'hFF});     // high byte
        send_str("gggggggA");    // eighth digit in one value
        send_str("AAAA,A");      // unsourced segment clears the hit
        send_str("C");           // column past the target

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p < 7)
            begin
                ln  = ph_line[p];
                col = ph_col[p];
                cnt = ph_cnt[p];
            end
            else
            begin
                ln  = $urandom_range(1, 3);
                col = $urandom_range(0, 40);
                cnt = $urandom_range(0, 511);
            end
            write_reg(REG_LOOKUP_LINE, 24'(ln));
            write_reg(REG_TARGET_COLUMN, 24'(col));
            write_reg(REG_NUM_SOURCES, 24'(cnt));
            cfg_valid <= 1'b0;
            settings_used++;

            if (p < 3)
            begin
                gap_pct = 38;
                stall_pct <= 56;
            end
            else if (p < 6)
            begin
                gap_pct = 56;
                stall_pct <= 38;
            end
            else
            begin
                gap_pct = 0;
                stall_pct <= 0;
            end
            // long receiver hold-off while characters keep coming
            if (p == 6) pressure_reqs <= pressure_reqs + 1;

            phase_end = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end)
            begin
                send_text(build_text());
            end
        end

        settle();
        $display("Sent %0d characters in %0d texts under %0d register settings",
                 sent_items, sent_texts, settings_used);
        $display("Checked %0d lookups: %0d matched, %0d malformed",
                 sb.results, sb.hits, sb.faults);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
